### sv/qrs_pkg.sv
// Package for the quadratic root solver: widths, cell payload types, shared helpers.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
package qrs_pkg;
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int DISC_BITS = 2 * WORD_BITS + 2;
  localparam int ROOT_BITS = WORD_BITS + 1;
  localparam int SQRT_STEPS = DISC_BITS / 2;
  localparam int Q_BITS = WORD_BITS + 2;
  localparam int NUM1_BITS = Q_BITS + FRAC_BITS + 1;
  localparam int DIV_STEPS = NUM1_BITS;
  localparam int DEN_BITS = Q_BITS + 1;

  // Square-root cell word
  typedef struct packed {
    logic                 valid;
    logic                 skip;
    logic                 lz;
    logic [DISC_BITS-1:0] rad;
    logic [DISC_BITS-1:0] rem;
    logic [ROOT_BITS-1:0] root;
    logic [WORD_BITS-1:0] ma;
    logic [WORD_BITS-1:0] mb;
    logic [WORD_BITS-1:0] mc;
    logic                 na;
    logic                 nb;
    logic                 nc;
  } sq_word_t;

  // Divider cell word: two restoring divisions in lock step
  typedef struct packed {
    logic                 valid;
    logic                 skip;
    logic                 lz;
    logic                 zq;
    logic [NUM1_BITS-1:0] n1;
    logic [DEN_BITS-1:0]  d1;
    logic [DEN_BITS:0]    r1;
    logic [NUM1_BITS-1:0] q1;
    logic [NUM1_BITS-1:0] n2;
    logic [DEN_BITS-1:0]  d2;
    logic [DEN_BITS:0]    r2;
    logic [NUM1_BITS-1:0] q2;
    logic                 neg1;
    logic                 neg2;
  } dv_word_t;

  // Clamp sign/magnitude to the word; flag when clamped
  function automatic logic [WORD_BITS:0] clamp_word(input logic [NUM1_BITS-1:0] mag,
                                                    input logic neg);
    logic [NUM1_BITS-1:0] lim;
    logic [WORD_BITS-1:0] m;
    logic                 sat;
    lim = (NUM1_BITS'(1) << (WORD_BITS - 1)) - (neg ? NUM1_BITS'(0) : NUM1_BITS'(1));
    sat = mag > lim;
    m = sat ? lim[WORD_BITS-1:0] : mag[WORD_BITS-1:0];
    return {sat, neg ? (~m + WORD_BITS'(1)) : m};
  endfunction
endpackage

### sv/qrs_sqrt_cell.sv
// One digit of the restoring square root: two radicand bits a cycle while en is high.
// Depends on qrs_pkg.
`timescale 1ns / 1ps
module qrs_sqrt_cell import qrs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  sq_word_t din,
  output sq_word_t dout
);
  sq_word_t             nx;
  logic [DISC_BITS-1:0] rem2;
  logic [DISC_BITS-1:0] trial;

  // Shift in the next pair and try the next root bit
  always_comb begin
    nx = din;
    rem2 = {din.rem[DISC_BITS-3:0], din.rad[DISC_BITS-1:DISC_BITS-2]};
    trial = DISC_BITS'({din.root, 2'b01});
    nx.rad = {din.rad[DISC_BITS-3:0], 2'b00};
    if (rem2 >= trial) begin
      nx.rem = rem2 - trial;
      nx.root = {din.root[ROOT_BITS-2:0], 1'b1};
    end else begin
      nx.rem = rem2;
      nx.root = {din.root[ROOT_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      {dout.skip, dout.lz, dout.rad, dout.rem, dout.root, dout.ma, dout.mb, dout.mc,
       dout.na, dout.nb, dout.nc} <=
        {nx.skip, nx.lz, nx.rad, nx.rem, nx.root, nx.ma, nx.mb, nx.mc,
         nx.na, nx.nb, nx.nc};
    end
  end
endmodule

### sv/qrs_div_cell.sv
// One quotient bit of both root divisions.
// Depends on qrs_pkg.
`timescale 1ns / 1ps
module qrs_div_cell import qrs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  dv_word_t din,
  output dv_word_t dout
);
  dv_word_t          nx;
  logic [DEN_BITS:0] s1;
  logic [DEN_BITS:0] s2;

  // Shift in a numerator bit, subtract the divisor when it fits
  always_comb begin
    nx = din;
    s1 = {din.r1[DEN_BITS-1:0], din.n1[NUM1_BITS-1]};
    s2 = {din.r2[DEN_BITS-1:0], din.n2[NUM1_BITS-1]};
    nx.n1 = {din.n1[NUM1_BITS-2:0], 1'b0};
    nx.n2 = {din.n2[NUM1_BITS-2:0], 1'b0};
    if (s1 >= {1'b0, din.d1}) begin
      nx.r1 = s1 - {1'b0, din.d1};
      nx.q1 = {din.q1[NUM1_BITS-2:0], 1'b1};
    end else begin
      nx.r1 = s1;
      nx.q1 = {din.q1[NUM1_BITS-2:0], 1'b0};
    end
    if (s2 >= {1'b0, din.d2}) begin
      nx.r2 = s2 - {1'b0, din.d2};
      nx.q2 = {din.q2[NUM1_BITS-2:0], 1'b1};
    end else begin
      nx.r2 = s2;
      nx.q2 = {din.q2[NUM1_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      {dout.skip, dout.lz, dout.zq, dout.n1, dout.d1, dout.r1, dout.q1, dout.n2, dout.d2,
       dout.r2, dout.q2, dout.neg1, dout.neg2} <=
        {nx.skip, nx.lz, nx.zq, nx.n1, nx.d1, nx.r1, nx.q1, nx.n2, nx.d2,
         nx.r2, nx.q2, nx.neg1, nx.neg2};
    end
  end
endmodule

### sv/quadratic_root_solver.sv
// Top level of the quadratic root solver: front multipliers, sqrt and divider cell rows.
// Depends on qrs_pkg, qrs_sqrt_cell and qrs_div_cell.
`timescale 1ns / 1ps
// Accepts one coefficient word every cycle unless the output stalls, and returns one result
// word per input, in order. Stages: multiply, discriminant, 33 square-root cells and 51
// divider cells at the default widths (SQRT_STEPS, DIV_STEPS), divider setup and output
// registers; the whole pipe stalls only while the output word is held unaccepted.
module quadratic_root_solver import qrs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,  // coef_a[31:0], coef_b[63:32], coef_c[95:64]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,  // root_low[31:0], root_high[63:32]
  output logic [2:0]  m_tuser   // has_roots[0], leading_zero_error[1], saturated[2]
);
  logic en;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en && !rst;

  // Stage 1: magnitudes and products
  logic                   p_valid, p_lz, p_na, p_nb, p_nc;
  logic [WORD_BITS-1:0]   p_ma, p_mb, p_mc;
  logic [2*WORD_BITS-1:0] p_bb, p_ac;
  logic [WORD_BITS-1:0]   ca, cb, cc, ma, mb, mc;
  assign ca = s_tdata[WORD_BITS-1:0];
  assign cb = s_tdata[2*WORD_BITS-1:WORD_BITS];
  assign cc = s_tdata[3*WORD_BITS-1:2*WORD_BITS];
  assign ma = ca[WORD_BITS-1] ? ~ca + WORD_BITS'(1) : ca;
  assign mb = cb[WORD_BITS-1] ? ~cb + WORD_BITS'(1) : cb;
  assign mc = cc[WORD_BITS-1] ? ~cc + WORD_BITS'(1) : cc;

  always_ff @(posedge clk) begin
    if (rst) p_valid <= 1'b0;
    else if (en) p_valid <= s_tvalid;
    if (en) begin
      p_ma <= ma; p_mb <= mb; p_mc <= mc;
      p_na <= ca[WORD_BITS-1]; p_nb <= cb[WORD_BITS-1]; p_nc <= cc[WORD_BITS-1];
      p_lz <= (ca == '0);
      p_bb <= mb * mb;
      p_ac <= ma * mc;
    end
  end

  // Stage 2: discriminant into the first sqrt cell
  sq_word_t sq [SQRT_STEPS+1];
  logic [DISC_BITS-1:0] bb_w, ac4_w;
  assign bb_w = DISC_BITS'(p_bb);
  assign ac4_w = {p_ac, 2'b00};
  always_ff @(posedge clk) begin
    if (rst) sq[0].valid <= 1'b0;
    else if (en) sq[0].valid <= p_valid;
    if (en) begin
      sq[0].lz <= p_lz;
      sq[0].rem <= '0;
      sq[0].root <= '0;
      sq[0].ma <= p_ma; sq[0].mb <= p_mb; sq[0].mc <= p_mc;
      sq[0].na <= p_na; sq[0].nb <= p_nb; sq[0].nc <= p_nc;
      if (p_mc != '0 && p_na != p_nc) begin
        sq[0].rad <= bb_w + ac4_w;
        sq[0].skip <= p_lz;
      end else begin
        sq[0].rad <= bb_w - ac4_w;
        sq[0].skip <= p_lz || (bb_w < ac4_w);
      end
    end
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sq
    qrs_sqrt_cell u_cell (.clk(clk), .rst(rst), .en(en), .din(sq[i]), .dout(sq[i+1]));
  end

  // Stage: round the root, form |2q| and the divider operands
  sq_word_t             st;
  dv_word_t             dv [DIV_STEPS+1];
  logic [ROOT_BITS-1:0] s_r;
  logic [Q_BITS-1:0]    qq;
  logic                 nq;
  assign st = sq[SQRT_STEPS];
  assign s_r = st.root + ROOT_BITS'(DISC_BITS'(st.rem) > DISC_BITS'(st.root));
  assign qq = Q_BITS'(st.mb) + Q_BITS'(s_r);
  assign nq = !st.nb;
  always_ff @(posedge clk) begin
    if (rst) dv[0].valid <= 1'b0;
    else if (en) dv[0].valid <= st.valid;
    if (en) begin
      dv[0].skip <= st.skip;
      dv[0].lz <= st.lz;
      dv[0].zq <= (qq == '0);
      // (2*qq<<F + 2a) / 4a and (2*c<<(F+1) + qq) / 2qq
      dv[0].n1 <= NUM1_BITS'({qq, {(FRAC_BITS + 1){1'b0}}})
                  + NUM1_BITS'({st.ma, 1'b0});
      dv[0].d1 <= DEN_BITS'({st.ma, 2'b00});
      dv[0].n2 <= NUM1_BITS'({st.mc, {(FRAC_BITS + 2){1'b0}}}) + NUM1_BITS'(qq);
      dv[0].d2 <= DEN_BITS'({qq, 1'b0});
      dv[0].r1 <= '0; dv[0].q1 <= '0;
      dv[0].r2 <= '0; dv[0].q2 <= '0;
      dv[0].neg1 <= nq != st.na;
      dv[0].neg2 <= nq != st.nc;
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_dv
    qrs_div_cell u_cell (.clk(clk), .rst(rst), .en(en), .din(dv[i]), .dout(dv[i+1]));
  end

  // Output: clamp, order, flag
  dv_word_t             fin;
  logic [WORD_BITS:0]   c1, c2;
  logic [WORD_BITS-1:0] r1, r2;
  logic                 sat;
  assign fin = dv[DIV_STEPS];
  assign c1 = clamp_word(fin.q1, fin.neg1 && fin.q1 != '0);
  assign c2 = clamp_word(fin.q2, fin.neg2 && fin.q2 != '0);
  always_comb begin
    r1 = fin.zq ? '0 : c1[WORD_BITS-1:0];
    r2 = fin.zq ? '0 : c2[WORD_BITS-1:0];
    sat = !fin.zq && (c1[WORD_BITS] || c2[WORD_BITS]);
    if (fin.skip) begin
      r1 = '0; r2 = '0; sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= fin.valid;
    if (en) begin
      if ($signed(r1) > $signed(r2)) m_tdata <= {r1, r2};
      else m_tdata <= {r2, r1};
      m_tuser <= {sat, fin.lz, !fin.skip};
    end
  end

  // A stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");
  // Zero a never reports roots
  a_lz: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[0] && m_tdata == '0)
    else $error("leading zero word carries roots");
  // Roots come out ordered
  a_ord: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $signed(m_tdata[31:0]) <= $signed(m_tdata[63:32]))
    else $error("roots out of order");
endmodule

### tb/tb_quadratic_root_solver.sv
// Testbench for the quadratic root solver: random and directed coefficient words,
// checked against a behavioral root predictor. Depends on qrs_pkg and the solver RTL.
`timescale 1ns / 1ps
module tb_quadratic_root_solver;
  import qrs_pkg::*;

  typedef struct packed {
    logic [31:0] root_low;
    logic [31:0] root_high;
    logic        has_roots;
    logic        lz_err;
    logic        sat;
  } roots_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [2:0]  m_tuser;

  logic [95:0] coef_words[$];
  roots_t      roots_due[$];
  int          cyc = 0;
  int          errors = 0;
  int          hold_left = 0;

  quadratic_root_solver dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  // Rounded integer square root of a 128-bit value
  function automatic logic [63:0] sqrt_round(input logic [127:0] x);
    logic [129:0] rem;
    logic [64:0]  root;
    logic [129:0] trial;
    rem = '0;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 2) | x[2*i +: 2];
      root = root << 1;
      trial = {root, 1'b1};
      if (rem >= trial) begin
        rem = rem - trial;
        root = root | 65'd1;
      end
    end
    if (rem > root) root = root + 65'd1;
    return root[63:0];
  endfunction

  // Clamp magnitude to the word; returns {sat, word}
  function automatic logic [32:0] clamp_root(input logic [127:0] mag, input logic neg);
    logic [127:0] lim;
    logic [31:0]  m;
    logic         sat;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    sat = mag > lim;
    m = sat ? lim[31:0] : mag[31:0];
    return {sat, neg ? -m : m};
  endfunction

  function automatic roots_t predict_roots(input logic [95:0] w);
    logic signed [31:0] a, b, c;
    logic [63:0]  ma, mb, mc, s, qq;
    logic         na, nb, nc, nq;
    logic [127:0] bb, ac4, disc, m1, m2;
    logic [32:0]  c1, c2;
    logic signed [31:0] r1, r2, t;
    roots_t res;
    res = '0;
    a = w[31:0];
    b = w[63:32];
    c = w[95:64];
    na = a[31];
    nb = b[31];
    nc = c[31];
    ma = na ? -{{32{a[31]}}, a} : {32'd0, a};
    mb = nb ? -{{32{b[31]}}, b} : {32'd0, b};
    mc = nc ? -{{32{c[31]}}, c} : {32'd0, c};
    if (ma == 0) begin
      res.lz_err = 1'b1;
      return res;
    end
    bb = mb * mb;
    ac4 = (128'(ma) * 128'(mc)) << 2;
    if (mc != 0 && na != nc) disc = bb + ac4;
    else begin
      if (bb < ac4) return res;
      disc = bb - ac4;
    end
    s = sqrt_round(disc);
    qq = mb + s;
    nq = !nb;
    r1 = '0;
    r2 = '0;
    c1 = '0;
    c2 = '0;
    if (qq != 0) begin
      // Round to nearest, ties away from zero: (2n + d) / 2d
      m1 = ((128'(qq) << 17) + 128'(ma << 1)) / (128'(ma) << 2);
      m2 = ((128'(mc) << 18) + 128'(qq)) / (128'(qq) << 1);
      c1 = clamp_root(m1, (nq != na) && m1 != 0);
      c2 = clamp_root(m2, (nq != nc) && m2 != 0);
      r1 = c1[31:0];
      r2 = c2[31:0];
    end
    if (r1 > r2) begin
      t = r1;
      r1 = r2;
      r2 = t;
    end
    res.root_low = r1;
    res.root_high = r2;
    res.has_roots = 1'b1;
    res.sat = c1[32] | c2[32];
    return res;
  endfunction

  function automatic logic [95:0] coef_word(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c);
    return {c, b, a};
  endfunction

  // Random value with a random magnitude class, to reach small and large coefficients
  function automatic logic [31:0] rand_coef();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(3))
      0: v = {{16{v[31]}}, v[15:0]};
      1: v = {{8{v[31]}}, v[23:0]};
      2: v = $signed(v[7:0]) <<< 16;
      default: ;
    endcase
    return v;
  endfunction

  // Fill the stimulus queue
  initial begin
    logic [31:0] a, b, c;
    int r1, r2, k;
    coef_words.push_back(coef_word(32'd0, 32'd0, 32'd0));
    coef_words.push_back(coef_word(32'd0, 32'h7fff_ffff, 32'h8000_0000));
    coef_words.push_back(coef_word(32'h0001_0000, 32'd0, 32'h0001_0000));
    coef_words.push_back(coef_word(32'h0001_0000, 32'd0, 32'd0));
    coef_words.push_back(coef_word(32'hffff_0000, 32'd0, 32'd0));
    coef_words.push_back(coef_word(32'h0001_0000, 32'h0002_0000, 32'h0001_0000));
    coef_words.push_back(coef_word(32'h0001_0000, 32'hfffd_0000, 32'h0002_0000));
    coef_words.push_back(coef_word(32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000));
    coef_words.push_back(coef_word(32'h0000_0001, 32'h8000_0000, 32'h7fff_ffff));
    coef_words.push_back(coef_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    coef_words.push_back(coef_word(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    coef_words.push_back(coef_word(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
    coef_words.push_back(coef_word(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    coef_words.push_back(coef_word(32'h0000_0001, 32'd0, 32'h0000_0001));
    coef_words.push_back(coef_word(32'h0000_0001, 32'd0, 32'hffff_ffff));
    coef_words.push_back(coef_word(32'h0001_0000, 32'h0000_0001, 32'd0));
    coef_words.push_back(coef_word(32'hffff_ffff, 32'h7fff_ffff, 32'h0000_0001));
    coef_words.push_back(coef_word(32'h0000_8000, 32'h0000_0000, 32'hffff_8000));
    // Random: half real-root triples built from chosen roots, the rest random-class or raw noise
    for (int i = 0; i < 450; i++) begin
      k = $urandom_range(9);
      if (k < 5) begin
        r1 = $signed($urandom_range(255)) - 128;
        r2 = $signed($urandom_range(255)) - 128;
        a = $signed($urandom_range(255)) - 128;
        if (a == 0) a = 1;
        b = -a * (r1 + r2) <<< 16;
        c = a * r1 * r2 <<< 16;
        a = a <<< 16;
        coef_words.push_back(coef_word(a, b, c));
      end else if (k < 9) begin
        coef_words.push_back(coef_word(rand_coef(), rand_coef(), rand_coef()));
      end else begin
        coef_words.push_back(coef_word(($urandom_range(1) != 0) ? 32'd0 : $urandom,
                                       $urandom, $urandom));
      end
    end
  end

  // Release reset from the cycle counter; count cycles and stop on timeout
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == 1) rst <= 1'b0;
    if (cyc > 200000) begin
      $display("quadratic_root_solver test failed");
      $finish;
    end
  end

  // Drive coefficient words, idling at random outside a quiet window
  always @(posedge clk) begin
    if (!rst && (!s_tvalid || s_tready)) begin
      if (coef_words.size() != 0 &&
          ((cyc >= 700 && cyc < 950) || $urandom_range(99) >= 26)) begin
        s_tvalid <= 1'b1;
        s_tdata <= coef_words.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: one long hold-off to fill the pipe, random stalls otherwise
  always @(posedge clk) begin
    if (cyc == 250) hold_left <= 400;
    else if (hold_left > 0) hold_left <= hold_left - 1;
    if (rst || hold_left > 1 || cyc == 250) m_tready <= 1'b0;
    else m_tready <= (cyc >= 700 && cyc < 950) || $urandom_range(99) >= 26;
  end

  // Predict on accepted input, compare on accepted output
  always @(posedge clk) begin
    roots_t exp_r, got;
    if (!rst) begin
      if (s_tvalid && s_tready) roots_due.push_back(predict_roots(s_tdata));
      if (m_tvalid && m_tready) begin
        got = {m_tdata[31:0], m_tdata[63:32], m_tuser[0], m_tuser[1], m_tuser[2]};
        if (roots_due.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result word %h", got);
        end else begin
          exp_r = roots_due.pop_front();
          if (got !== exp_r) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: lo %h/%h hi %h/%h has %b/%b lz %b/%b sat %b/%b",
                       exp_r.root_low, got.root_low, exp_r.root_high, got.root_high,
                       exp_r.has_roots, got.has_roots, exp_r.lz_err, got.lz_err,
                       exp_r.sat, got.sat);
          end
        end
      end
    end
  end

  // Wait for the stream to drain, then let the pipe settle
  initial begin
    wait (!rst);
    wait (coef_words.size() == 0 && !s_tvalid && roots_due.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && roots_due.size() == 0) $display("quadratic_root_solver test passed");
    else $display("quadratic_root_solver test failed");
    $finish;
  end
endmodule

### files.f
sv/qrs_pkg.sv
sv/qrs_sqrt_cell.sv
sv/qrs_div_cell.sv
sv/quadratic_root_solver.sv
tb/tb_quadratic_root_solver.sv
